// File: rtl/core/priority_route_table_defines.svh
// Assertion macros shared by the route table RTL.
`ifndef PRIORITY_ROUTE_TABLE_DEFINES_SVH
`define PRIORITY_ROUTE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, ignored while rst is high.
`define PRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("route table check failed");

// Next-cycle implication, sampled on clk, ignored while rst is high.
`define PRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("route table check failed");

`endif

// File: rtl/core/prt_pkg.sv
// Shared types and constants of the priority route table.
package prt_pkg;

  localparam int MAX_ENTRIES       = 64;
  localparam int DEF_ROUTE_ENTRIES = 8;
  localparam int IDX_W             = $clog2(MAX_ENTRIES);

  localparam int OP_W     = 2;
  localparam int NET_W    = 32;
  localparam int NODE_W   = 48;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 3;

  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_NET = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DIRECT   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NETSET   = 3'd5;

  localparam logic signed [PRIO_W-1:0] PRIO_MIN = -8'sd128;
  localparam logic signed [PRIO_W-1:0] PRIO_MAX = 8'sd127;
  localparam logic signed [PRIO_W-1:0] PRIO_CAP = 8'sd124;
  localparam logic signed [PRIO_W:0]   PRIO_CAP_LIMIT = 9'sd125;
  localparam logic signed [PRIO_W:0]   PRIO_STEP      = 9'sd3;

  // Search token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic                     active;
    logic [NET_W-1:0]         key;
    logic signed [PRIO_W-1:0] prio_req;
    logic                     found;
    logic [IDX_W-1:0]         found_idx;
    logic [NODE_W-1:0]        found_gw;
    logic signed [PRIO_W-1:0] found_prio;
    logic                     weak_found;
    logic [IDX_W-1:0]         weak_idx;
    logic signed [PRIO_W-1:0] min_prio;
    logic [IDX_W-1:0]         min_idx;
  } scan_tok_t;

  // Entry update broadcast from the controller to every cell.
  typedef struct packed {
    logic                     en;
    logic                     full;
    logic [IDX_W-1:0]         idx;
    logic [NET_W-1:0]         network;
    logic [NODE_W-1:0]        gateway;
    logic signed [PRIO_W-1:0] prio;
  } entry_wr_t;

endpackage

// File: rtl/core/prt_if.sv
// Request and response channel interfaces of the route table.
interface route_req_if import prt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [NET_W-1:0]         network;
  logic [NODE_W-1:0]        node;
  logic signed [PRIO_W-1:0] priority_req;
  logic [NET_W-1:0]         packet_dest_network;

  modport source (output valid, opcode, network, node, priority_req,
                  packet_dest_network, input ready);
  modport sink (input valid, opcode, network, node, priority_req,
                packet_dest_network, output ready);
endinterface

interface route_rsp_if import prt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [NODE_W-1:0]    next_hop;
  logic [NET_W-1:0]     local_net;

  modport source (output valid, status, next_hop, local_net, input ready);
  modport sink (input valid, status, next_hop, local_net, output ready);
endinterface

// File: rtl/core/prt_cell.sv
// One route table entry with its stage of the search token chain.
module prt_cell import prt_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  scan_tok_t tok_in,
  output scan_tok_t tok_out,
  input  entry_wr_t wr
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [NET_W-1:0]         network;
  logic [NODE_W-1:0]        gateway;
  logic signed [PRIO_W-1:0] prio;
  scan_tok_t                tok_next;

  // First match on the key, first entry weaker than the request, and the
  // first strictly lowest priority, each folded into the passing token.
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.found && (network == tok_in.key)) begin
      tok_next.found      = 1'b1;
      tok_next.found_idx  = MY_IDX;
      tok_next.found_gw   = gateway;
      tok_next.found_prio = prio;
    end
    if (!tok_in.weak_found && (prio < tok_in.prio_req)) begin
      tok_next.weak_found = 1'b1;
      tok_next.weak_idx   = MY_IDX;
    end
    if (prio < tok_in.min_prio) begin
      tok_next.min_prio = prio;
      tok_next.min_idx  = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      network        <= '0;
      gateway        <= '0;
      prio           <= PRIO_MIN;
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (wr.en && (wr.idx == MY_IDX)) begin
        prio <= wr.prio;
        if (wr.full) begin
          network <= wr.network;
          gateway <= wr.gateway;
        end
      end
    end
  end

endmodule

// File: rtl/core/priority_route_table.sv
// Top level of the priority route table: controller and chain of entry cells.
// Searching lookups and inserts: the token passes the launch register and each cell's
// output register, then the result is captured and committed to the response register.
// Direct lookups, local network sets and unused opcodes go straight to the done state.
// One transaction at a time; a response held off by the sink stalls the next commit.
// Synchronous reset empties every entry, sets priorities to -128, clears local.
`include "priority_route_table_defines.svh"

module priority_route_table import prt_pkg::*; #(
  parameter int ROUTE_ENTRIES = DEF_ROUTE_ENTRIES
) (
  input  logic         clk,
  input  logic         rst,
  route_req_if.sink    req,
  route_rsp_if.source  rsp
);

  // One-hot controller states: take a request, wait for a searching request's token to
  // leave the last cell, then commit the entry update and the response.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } ctrl_state_t;

  ctrl_state_t state, state_next;

  // The token chain: element 0 is the launch register, element i + 1 is the
  // output register of cell i, and the last element is the tail.
  scan_tok_t chain [ROUTE_ENTRIES+1];
  scan_tok_t head_tok, head_tok_next;
  scan_tok_t res_tok;
  entry_wr_t wr, wr_d;
  logic [ROUTE_ENTRIES:0] tok_active;

  // Captured request fields for the transaction in flight.
  logic [OP_W-1:0]          op_q;
  logic [NET_W-1:0]         net_q;
  logic [NODE_W-1:0]        node_q;
  logic signed [PRIO_W-1:0] prio_q;
  logic                     skip_q;

  logic [NET_W-1:0] local_network;

  // Response holding register: a finished result waits here while the
  // block is already free to take the next request transaction.
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [NODE_W-1:0]   out_hop;
  logic [NET_W-1:0]    out_local;

  logic                     acc;
  logic                     needs_scan;
  logic                     fire;
  logic [STATUS_W-1:0]      status_d;
  logic [NODE_W-1:0]        hop_d;
  logic signed [PRIO_W:0]   bumped;
  logic signed [PRIO_W-1:0] bumped_cap;

  assign req.ready = (state == ST_IDLE);
  assign acc       = req.valid && req.ready;

  // Only a lookup that is not for the local network and an insert need to
  // search the table; everything else is answered without touching it.
  assign needs_scan = ((req.opcode == OP_LOOKUP) && (req.network != local_network)) ||
                      (req.opcode == OP_INSERT);

  assign fire = (state == ST_DONE) && (!out_valid || rsp.ready);

  // A launched token searches for the target network on a lookup and for an
  // empty entry (network zero) on an insert.
  always_comb begin
    head_tok_next        = head_tok;
    head_tok_next.active = 1'b0;
    if (acc) begin
      head_tok_next.active     = needs_scan;
      head_tok_next.key        = (req.opcode == OP_LOOKUP) ? req.network : '0;
      head_tok_next.prio_req   = req.priority_req;
      head_tok_next.found      = 1'b0;
      head_tok_next.found_idx  = '0;
      head_tok_next.found_gw   = '0;
      head_tok_next.found_prio = PRIO_MIN;
      head_tok_next.weak_found = 1'b0;
      head_tok_next.weak_idx   = '0;
      head_tok_next.min_prio   = PRIO_MAX;
      head_tok_next.min_idx    = '0;
    end
  end

  assign chain[0] = head_tok;

  genvar gi;
  generate
    for (gi = 0; gi < ROUTE_ENTRIES; gi++) begin : g_cell
      prt_cell #(
        .INDEX (gi)
      ) u_cell (
        .clk     (clk),
        .rst     (rst),
        .tok_in  (chain[gi]),
        .tok_out (chain[gi+1]),
        .wr      (wr)
      );
    end
    for (gi = 0; gi <= ROUTE_ENTRIES; gi++) begin : g_act
      assign tok_active[gi] = chain[gi].active;
    end
  endgenerate

  // A hit raises the priority by three without wrapping; anything above the
  // cap limit is pulled back to the cap.
  assign bumped     = {res_tok.found_prio[PRIO_W-1], res_tok.found_prio} + PRIO_STEP;
  assign bumped_cap = (bumped > PRIO_CAP_LIMIT) ? PRIO_CAP : bumped[PRIO_W-1:0];

  // Result and entry update from the finished token. A miss only knocks the
  // weakest entry down to the floor priority; its network and gateway stay.
  always_comb begin
    status_d   = ST_DROPPED;
    hop_d      = '0;
    wr_d       = '0;
    wr_d.network = net_q;
    wr_d.gateway = node_q;
    wr_d.prio    = prio_q;
    if (skip_q) begin
      if (op_q == OP_LOOKUP) begin
        status_d = ST_DIRECT;
        hop_d    = node_q;
      end else if (op_q == OP_SET_NET) begin
        status_d = ST_NETSET;
      end
    end else if (op_q == OP_LOOKUP) begin
      wr_d.en = 1'b1;
      if (res_tok.found) begin
        status_d  = ST_HIT;
        hop_d     = res_tok.found_gw;
        wr_d.idx  = res_tok.found_idx;
        wr_d.prio = bumped_cap;
      end else begin
        status_d  = ST_MISS;
        wr_d.idx  = res_tok.min_idx;
        wr_d.prio = PRIO_MIN;
      end
    end else begin
      // Insert: an empty entry wins, then the first weaker entry.
      if (res_tok.found) begin
        status_d  = ST_INSERTED;
        wr_d.en   = 1'b1;
        wr_d.full = 1'b1;
        wr_d.idx  = res_tok.found_idx;
      end else if (res_tok.weak_found) begin
        status_d  = ST_INSERTED;
        wr_d.en   = 1'b1;
        wr_d.full = 1'b1;
        wr_d.idx  = res_tok.weak_idx;
      end
    end
  end

  always_comb begin
    wr    = wr_d;
    wr.en = wr_d.en && fire;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          state_next = needs_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (chain[ROUTE_ENTRIES].active) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      head_tok.active <= 1'b0;
      local_network   <= '0;
      out_valid       <= 1'b0;
    end else begin
      state    <= state_next;
      head_tok <= head_tok_next;
      // The local network is set by a set-net request, or learned from an insert while it
      // is still unset, whether or not the route itself is then stored.
      if (acc && (req.opcode == OP_SET_NET)) begin
        local_network <= req.network;
      end else if (acc && (req.opcode == OP_INSERT) && (local_network == '0)) begin
        local_network <= req.packet_dest_network;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_q   <= req.opcode;
      net_q  <= req.network;
      node_q <= req.node;
      prio_q <= req.priority_req;
      skip_q <= !needs_scan;
    end
    if ((state == ST_SCAN) && chain[ROUTE_ENTRIES].active) begin
      res_tok <= chain[ROUTE_ENTRIES];
    end
    if (fire) begin
      out_status <= status_d;
      out_hop    <= hop_d;
      out_local  <= local_network;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.next_hop  = out_hop;
  assign rsp.local_net = out_local;

  // At most one search token is ever in the chain.
  `PRT_ASSERT_NOW(a_one_token, 1'b1, $countones(tok_active) <= 1)
  // The token leaves the last cell only while the controller waits for it.
  `PRT_ASSERT_NOW(a_tail_in_scan, chain[ROUTE_ENTRIES].active, state == ST_SCAN)
  // Entries change only when a result is committed.
  `PRT_ASSERT_NOW(a_write_on_done, wr.en, (state == ST_DONE) && fire)
  // A taken request blocks the next one until its result is committed.
  `PRT_ASSERT_NEXT(a_busy_after_accept, acc, !req.ready)
  // Every committed result appears on the response port in the next cycle.
  `PRT_ASSERT_NEXT(a_result_shown, fire, out_valid)

endmodule
